/* rtl/tsalu_pkg.sv */
// tsalu_pkg: shared constants, codes and types of the tagged stack alu
// no dependencies; used by every rtl file of the block
`timescale 1ns / 1ps
`default_nettype none

package tsalu_pkg;

    // parameter defaults
    localparam int DATA_WIDTH_DEF  = 32;
    localparam int STACK_DEPTH_DEF = 16;

    // fixed field widths
    localparam int PUSH_VALUE_W = 32;
    localparam int DEPTH_OUT_W  = 5;

    // operation kinds
    localparam logic [1:0] OPN_PUSH   = 2'd0;
    localparam logic [1:0] OPN_UNARY  = 2'd1;
    localparam logic [1:0] OPN_BINARY = 2'd2;
    localparam logic [1:0] OPN_NONE   = 2'd3;

    // opcodes
    localparam logic [3:0] OP_NEG  = 4'd0;
    localparam logic [3:0] OP_LNOT = 4'd1;
    localparam logic [3:0] OP_INV  = 4'd2;
    localparam logic [3:0] OP_ADD  = 4'd3;
    localparam logic [3:0] OP_SUB  = 4'd4;
    localparam logic [3:0] OP_MUL  = 4'd5;
    localparam logic [3:0] OP_DIV  = 4'd6;
    localparam logic [3:0] OP_MOD  = 4'd7;
    localparam logic [3:0] OP_AND  = 4'd8;
    localparam logic [3:0] OP_OR   = 4'd9;
    localparam logic [3:0] OP_XOR  = 4'd10;
    localparam logic [3:0] OP_LAND = 4'd11;
    localparam logic [3:0] OP_LOR  = 4'd12;

    // tags
    localparam logic [1:0] TAG_INT  = 2'd0;
    localparam logic [1:0] TAG_UNS  = 2'd1;
    localparam logic [1:0] TAG_BOOL = 2'd2;

    // status codes
    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_EMPTY       = 3'd1;
    localparam logic [2:0] ST_EXP_INT     = 3'd2;
    localparam logic [2:0] ST_EXP_INT_UNS = 3'd3;
    localparam logic [2:0] ST_DIV0        = 3'd4;
    localparam logic [2:0] ST_OVERFLOW    = 3'd5;
    localparam logic [2:0] ST_UNK_UNARY   = 3'd6;
    localparam logic [2:0] ST_UNK_BINARY  = 3'd7;

    // multiply / divide unit modes
    localparam logic [1:0] MD_MUL = 2'd0;
    localparam logic [1:0] MD_DIV = 2'd1;
    localparam logic [1:0] MD_MOD = 2'd2;

    // classified command handed from front to back
    typedef struct packed {
        logic [1:0] kind;
        logic [3:0] opcode;
        logic       op_known;
        logic [1:0] tag;
    } t_cmd;

    // request to the multiply / divide unit
    typedef struct packed {
        logic       start;
        logic [1:0] mode;
    } t_mdu_req;

endpackage

`default_nettype wire

/* rtl/tsalu_front.sv */
// tsalu_front: accepts input words, classifies them, two-entry queue to the back
// depends on tsalu_pkg
`timescale 1ns / 1ps
`default_nettype none

module tsalu_front #(
    parameter int DATA_WIDTH = tsalu_pkg::DATA_WIDTH_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_valid,
    output logic                                     o_stall,
    input  wire logic [1:0]                          i_operation,
    input  wire logic [3:0]                          i_opcode,
    input  wire logic [tsalu_pkg::PUSH_VALUE_W-1:0]  i_push_value,
    input  wire logic [1:0]                          i_push_type,
    output logic                                     o_q_valid,
    output tsalu_pkg::t_cmd                          o_q_cmd,
    output logic [DATA_WIDTH-1:0]                    o_q_value,
    input  wire logic                                i_q_pop
);

    tsalu_pkg::t_cmd       r_q_cmd [2];
    logic [DATA_WIDTH-1:0] r_q_val [2];
    logic                  r_wr_ptr, n_wr_ptr;
    logic                  r_rd_ptr, n_rd_ptr;
    logic [1:0]            r_q_cnt, n_q_cnt;

    tsalu_pkg::t_cmd w_cmd;
    logic [63:0]     w_val64;
    logic            w_push;
    logic            w_pop;

    // classify the incoming word
    always_comb begin
        w_cmd.kind   = i_operation;
        w_cmd.opcode = i_opcode;
        w_cmd.tag    = i_push_type;
        unique case (i_operation)
            tsalu_pkg::OPN_UNARY:  w_cmd.op_known = (i_opcode <= tsalu_pkg::OP_INV);
            tsalu_pkg::OPN_BINARY: w_cmd.op_known = (i_opcode >= tsalu_pkg::OP_ADD) &&
                                                    (i_opcode <= tsalu_pkg::OP_LOR);
            default:               w_cmd.op_known = 1'b1;
        endcase
    end

    assign w_val64 = 64'(i_push_value);
    assign o_stall = (r_q_cnt == 2'd2);
    assign w_push  = i_valid && !o_stall;
    assign w_pop   = i_q_pop && o_q_valid;

    assign o_q_valid = (r_q_cnt != 2'd0);
    assign o_q_cmd   = r_q_cmd[r_rd_ptr];
    assign o_q_value = r_q_val[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr ^ w_push;
        n_rd_ptr = r_rd_ptr ^ w_pop;
        n_q_cnt  = r_q_cnt + 2'(w_push) - 2'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_q_cnt  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_q_cnt  <= n_q_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q_cmd[r_wr_ptr] <= w_cmd;
            r_q_val[r_wr_ptr] <= w_val64[DATA_WIDTH-1:0];
        end
    end

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_q_cnt <= 2'd2) else $error("queue count out of range");
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_q_cnt == 2'd0) |-> !w_pop) else $error("pop from empty queue");
    a_cnt_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && !w_pop) |=> (r_q_cnt == $past(r_q_cnt) + 2'd1))
        else $error("queue count lost a word");

endmodule

`default_nettype wire

/* rtl/tsalu_mdu.sv */
// tsalu_mdu: iterative shift-add multiplier and restoring divider, one bit per cycle
// depends on tsalu_pkg
`timescale 1ns / 1ps
`default_nettype none

module tsalu_mdu #(
    parameter int DATA_WIDTH = tsalu_pkg::DATA_WIDTH_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  tsalu_pkg::t_mdu_req        i_req,
    input  wire logic [DATA_WIDTH-1:0] i_a,
    input  wire logic [DATA_WIDTH-1:0] i_b,
    output logic                       o_done,
    output logic [DATA_WIDTH-1:0]      o_result
);

    localparam int CNT_W = $clog2(DATA_WIDTH + 1);

    logic                  r_busy, n_busy;
    logic                  r_fin, n_fin;
    logic [CNT_W-1:0]      r_cnt, n_cnt;
    logic [1:0]            r_mode, n_mode;
    logic                  r_neg_q, n_neg_q;
    logic                  r_neg_r, n_neg_r;
    logic [DATA_WIDTH-1:0] r_x, n_x;
    logic [DATA_WIDTH-1:0] r_y, n_y;
    logic [DATA_WIDTH-1:0] r_acc, n_acc;
    logic                  r_done, n_done;
    logic [DATA_WIDTH-1:0] r_res, n_res;

    always_comb begin
        logic [DATA_WIDTH:0]   v_rem_sh;
        logic [DATA_WIDTH+1:0] v_diff;
        logic                  v_qbit;
        v_rem_sh = {r_acc, r_x[DATA_WIDTH-1]};
        v_diff   = {1'b0, v_rem_sh} - {2'b00, r_y};
        v_qbit   = !v_diff[DATA_WIDTH+1];
        n_busy   = r_busy;
        n_fin    = 1'b0;
        n_cnt    = r_cnt;
        n_mode   = r_mode;
        n_neg_q  = r_neg_q;
        n_neg_r  = r_neg_r;
        n_x      = r_x;
        n_y      = r_y;
        n_acc    = r_acc;
        n_done   = 1'b0;
        n_res    = r_res;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = CNT_W'(DATA_WIDTH);
            n_mode = i_req.mode;
            n_acc  = '0;
            if (i_req.mode == tsalu_pkg::MD_MUL) begin
                n_x = i_a;
                n_y = i_b;
            end else begin
                // operate on magnitudes, fix signs at the end
                n_x = i_a[DATA_WIDTH-1] ? (DATA_WIDTH'(0) - i_a) : i_a;
                n_y = i_b[DATA_WIDTH-1] ? (DATA_WIDTH'(0) - i_b) : i_b;
            end
            n_neg_q = i_a[DATA_WIDTH-1] ^ i_b[DATA_WIDTH-1];
            n_neg_r = i_a[DATA_WIDTH-1];
        end else if (r_busy) begin
            if (r_mode == tsalu_pkg::MD_MUL) begin
                if (r_y[0]) n_acc = r_acc + r_x;
                n_x = r_x << 1;
                n_y = r_y >> 1;
            end else begin
                n_acc = v_qbit ? v_diff[DATA_WIDTH-1:0] : v_rem_sh[DATA_WIDTH-1:0];
                n_x   = {r_x[DATA_WIDTH-2:0], v_qbit};
            end
            n_cnt = r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
                n_fin  = 1'b1;
            end
        end
        if (r_fin) begin
            n_done = 1'b1;
            case (r_mode)
                tsalu_pkg::MD_MUL: n_res = r_acc;
                tsalu_pkg::MD_DIV: n_res = r_neg_q ? (DATA_WIDTH'(0) - r_x) : r_x;
                default:           n_res = r_neg_r ? (DATA_WIDTH'(0) - r_acc) : r_acc;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_fin  <= n_fin;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt   <= n_cnt;
        r_mode  <= n_mode;
        r_neg_q <= n_neg_q;
        r_neg_r <= n_neg_r;
        r_x     <= n_x;
        r_y     <= n_y;
        r_acc   <= n_acc;
        r_res   <= n_res;
    end

    assign o_done   = r_done;
    assign o_result = r_res;

    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !i_req.start) else $error("unit restarted while busy");
    a_done_after_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fin |=> r_done) else $error("finish without done");
    a_busy_fin_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_busy && r_fin)) else $error("busy and finishing together");

endmodule

`default_nettype wire

/* rtl/tsalu_back.sv */
// tsalu_back: operand stack memory, execution sequencer and output register
// depends on tsalu_pkg and tsalu_mdu
`timescale 1ns / 1ps
`default_nettype none

module tsalu_back #(
    parameter int DATA_WIDTH  = tsalu_pkg::DATA_WIDTH_DEF,
    parameter int STACK_DEPTH = tsalu_pkg::STACK_DEPTH_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_q_valid,
    input  tsalu_pkg::t_cmd                         i_q_cmd,
    input  wire logic [DATA_WIDTH-1:0]              i_q_value,
    output logic                                    o_q_pop,
    output logic                                    o_valid,
    input  wire logic                               i_stall,
    output logic [2:0]                              o_status,
    output logic [tsalu_pkg::PUSH_VALUE_W-1:0]      o_result_value,
    output logic [1:0]                              o_result_type,
    output logic [tsalu_pkg::DEPTH_OUT_W-1:0]       o_stack_depth
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RDB  = 3'd1;
    localparam logic [2:0] S_RDA  = 3'd2;
    localparam logic [2:0] S_EXEC = 3'd3;
    localparam logic [2:0] S_WAIT = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    logic [DATA_WIDTH-1:0] mem_val [STACK_DEPTH];
    logic [1:0]            mem_tag [STACK_DEPTH];

    logic [2:0]            r_state, n_state;
    logic [CW-1:0]         r_cnt, n_cnt;
    tsalu_pkg::t_cmd       r_cmd, n_cmd;
    logic [DATA_WIDTH-1:0] r_a, n_a, r_b, n_b;
    logic [1:0]            r_ta, n_ta, r_tb, n_tb;
    logic [2:0]            r_res_st, n_res_st;
    logic [DATA_WIDTH-1:0] r_res_val, n_res_val;
    logic [1:0]            r_res_tag, n_res_tag;
    logic                  r_res_push, n_res_push;
    logic [DATA_WIDTH-1:0] r_rd_val;
    logic [1:0]            r_rd_tag;
    logic                  r_out_valid, n_out_valid;
    logic [2:0]            r_out_st;
    logic [DATA_WIDTH-1:0] r_out_val;
    logic [1:0]            r_out_tag;
    logic [CW-1:0]         r_out_cnt;

    logic                  w_rd_en;
    logic [CW-1:0]         w_cnt_dec;
    logic                  w_we;
    logic                  w_out_free;
    logic                  w_out_load;
    tsalu_pkg::t_mdu_req   w_mdu_req;
    logic                  w_mdu_done;
    logic [DATA_WIDTH-1:0] w_mdu_res;
    logic [63:0]           w_out_val64;
    logic [31:0]           w_out_cnt32;

    assign w_out_free = !r_out_valid || !i_stall;
    assign w_cnt_dec  = r_cnt - CW'(1);

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_cmd      = r_cmd;
        n_a        = r_a;
        n_b        = r_b;
        n_ta       = r_ta;
        n_tb       = r_tb;
        n_res_st   = r_res_st;
        n_res_val  = r_res_val;
        n_res_tag  = r_res_tag;
        n_res_push = r_res_push;
        o_q_pop    = 1'b0;
        w_rd_en    = 1'b0;
        w_we       = 1'b0;
        w_out_load = 1'b0;
        w_mdu_req  = '{start: 1'b0, mode: tsalu_pkg::MD_MUL};
        unique case (r_state)
            S_IDLE: begin
                n_res_st   = tsalu_pkg::ST_OK;
                n_res_val  = '0;
                n_res_tag  = tsalu_pkg::TAG_INT;
                n_res_push = 1'b0;
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    n_cmd   = i_q_cmd;
                    unique case (i_q_cmd.kind) inside
                        tsalu_pkg::OPN_PUSH: begin
                            n_state = S_DONE;
                            if (r_cnt >= CW'(STACK_DEPTH)) begin
                                n_res_st = tsalu_pkg::ST_OVERFLOW;
                            end else begin
                                n_res_val  = i_q_value;
                                n_res_tag  = i_q_cmd.tag;
                                n_res_push = 1'b1;
                            end
                        end
                        tsalu_pkg::OPN_UNARY, tsalu_pkg::OPN_BINARY: begin
                            if (r_cnt == '0) begin
                                n_res_st = tsalu_pkg::ST_EMPTY;
                                n_state  = S_DONE;
                            end else begin
                                w_rd_en = 1'b1;
                                n_cnt   = w_cnt_dec;
                                n_state = S_RDB;
                            end
                        end
                        default: n_state = S_DONE;
                    endcase
                end
            end
            S_RDB: begin
                if (r_cmd.kind == tsalu_pkg::OPN_UNARY) begin
                    n_a     = r_rd_val;
                    n_ta    = r_rd_tag;
                    n_state = S_EXEC;
                end else begin
                    n_b  = r_rd_val;
                    n_tb = r_rd_tag;
                    if (r_cnt == '0) begin
                        n_res_st = tsalu_pkg::ST_EMPTY;
                        n_state  = S_DONE;
                    end else begin
                        w_rd_en = 1'b1;
                        n_cnt   = w_cnt_dec;
                        n_state = S_RDA;
                    end
                end
            end
            S_RDA: begin
                n_a     = r_rd_val;
                n_ta    = r_rd_tag;
                n_state = S_EXEC;
            end
            S_EXEC: begin
                n_state    = S_DONE;
                n_res_push = 1'b1;
                if (r_cmd.kind == tsalu_pkg::OPN_UNARY) begin
                    unique case (r_cmd.opcode)
                        tsalu_pkg::OP_NEG: begin
                            n_res_val = DATA_WIDTH'(0) - r_a;
                            if (r_ta != tsalu_pkg::TAG_INT) n_res_st = tsalu_pkg::ST_EXP_INT;
                        end
                        tsalu_pkg::OP_LNOT: begin
                            n_res_val = DATA_WIDTH'(r_a == '0);
                            if (r_ta != tsalu_pkg::TAG_BOOL) n_res_st = tsalu_pkg::ST_EXP_INT;
                        end
                        tsalu_pkg::OP_INV: begin
                            n_res_val = ~r_a;
                            if (r_ta != tsalu_pkg::TAG_INT && r_ta != tsalu_pkg::TAG_UNS)
                                n_res_st = tsalu_pkg::ST_EXP_INT_UNS;
                        end
                        default: n_res_st = tsalu_pkg::ST_UNK_UNARY;
                    endcase
                end else if (!r_cmd.op_known) begin
                    n_res_st = tsalu_pkg::ST_UNK_BINARY;
                end else if (r_ta != tsalu_pkg::TAG_INT || r_tb != tsalu_pkg::TAG_INT) begin
                    n_res_st = tsalu_pkg::ST_EXP_INT;
                end else begin
                    case (r_cmd.opcode) inside
                        tsalu_pkg::OP_ADD: n_res_val = r_a + r_b;
                        tsalu_pkg::OP_SUB: n_res_val = r_a - r_b;
                        tsalu_pkg::OP_MUL: begin
                            w_mdu_req = '{start: 1'b1, mode: tsalu_pkg::MD_MUL};
                            n_state   = S_WAIT;
                        end
                        tsalu_pkg::OP_DIV, tsalu_pkg::OP_MOD: begin
                            if (r_b == '0) begin
                                n_res_st = tsalu_pkg::ST_DIV0;
                            end else begin
                                w_mdu_req.start = 1'b1;
                                w_mdu_req.mode  = (r_cmd.opcode == tsalu_pkg::OP_DIV) ?
                                                  tsalu_pkg::MD_DIV : tsalu_pkg::MD_MOD;
                                n_state = S_WAIT;
                            end
                        end
                        tsalu_pkg::OP_AND:  n_res_val = r_a & r_b;
                        tsalu_pkg::OP_OR:   n_res_val = r_a | r_b;
                        tsalu_pkg::OP_XOR:  n_res_val = r_a ^ r_b;
                        tsalu_pkg::OP_LAND: n_res_val = DATA_WIDTH'((r_a != '0) && (r_b != '0));
                        default:            n_res_val = DATA_WIDTH'((r_a != '0) || (r_b != '0));
                    endcase
                end
                // any failed check pushes nothing
                if (n_res_st != tsalu_pkg::ST_OK) begin
                    n_res_push = 1'b0;
                    n_res_val  = '0;
                end
            end
            S_WAIT: begin
                if (w_mdu_done) begin
                    n_res_val = w_mdu_res;
                    n_state   = S_DONE;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    w_out_load = 1'b1;
                    w_we       = r_res_push;
                    if (r_res_push) n_cnt = r_cnt + CW'(1);
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_out_load)    n_out_valid = 1'b1;
        else if (!i_stall) n_out_valid = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_a        <= n_a;
        r_b        <= n_b;
        r_ta       <= n_ta;
        r_tb       <= n_tb;
        r_res_st   <= n_res_st;
        r_res_val  <= n_res_val;
        r_res_tag  <= n_res_tag;
        r_res_push <= n_res_push;
        if (w_out_load) begin
            r_out_st  <= r_res_st;
            r_out_val <= r_res_val;
            r_out_tag <= r_res_tag;
            r_out_cnt <= r_res_push ? (r_cnt + CW'(1)) : r_cnt;
        end
    end

    // stack memory, one write and one registered read a cycle
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem_val[r_cnt[AW-1:0]] <= r_res_val;
            mem_tag[r_cnt[AW-1:0]] <= r_res_tag;
        end
        if (w_rd_en) begin
            r_rd_val <= mem_val[w_cnt_dec[AW-1:0]];
            r_rd_tag <= mem_tag[w_cnt_dec[AW-1:0]];
        end
    end

    tsalu_mdu #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_mdu (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (w_mdu_req),
        .i_a      (r_a),
        .i_b      (r_b),
        .o_done   (w_mdu_done),
        .o_result (w_mdu_res)
    );

    assign w_out_val64    = 64'(r_out_val);
    assign w_out_cnt32    = 32'(r_out_cnt);
    assign o_valid        = r_out_valid;
    assign o_status       = r_out_st;
    assign o_result_value = w_out_val64[tsalu_pkg::PUSH_VALUE_W-1:0];
    assign o_result_type  = r_out_tag;
    assign o_stack_depth  = w_out_cnt32[tsalu_pkg::DEPTH_OUT_W-1:0];

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(STACK_DEPTH)) else $error("stack count beyond depth");
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> (r_cnt < CW'(STACK_DEPTH))) else $error("write into full stack");
    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mdu_done |-> (r_state == S_WAIT)) else $error("unit result outside wait");
    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_load |=> (o_valid && o_stack_depth == $past(n_cnt[tsalu_pkg::DEPTH_OUT_W-1:0])
                        || CW > tsalu_pkg::DEPTH_OUT_W))
        else $error("loaded word does not show the new depth");

endmodule

`default_nettype wire

/* rtl/tagged_stack_alu.sv */
// tagged_stack_alu: top level, front classifier and queue, back executor with stack
// depends on tsalu_pkg, tsalu_front, tsalu_back (and tsalu_mdu below it)
`timescale 1ns / 1ps
`default_nettype none

// channel   direction  handshake          payload
// input     in         i_valid / o_stall  i_operation, i_opcode, i_push_value, i_push_type
// result    out        o_valid / i_stall  o_status, o_result_value, o_result_type,
//                                         o_stack_depth
//
// a word waits in the front queue until the back sequencer pops and runs it:
// push and no-op pass S_IDLE and S_DONE; unary S_IDLE, S_RDB, S_EXEC, S_DONE;
// binary adds S_RDA; mul, div and mod add S_WAIT for the bit-per-cycle multiply/divide unit
// the stack memory gives one registered read a cycle, so each pop has its own read state
// reset (synchronous, active low) empties the stack; the memory itself is not cleared
// the front keeps taking words while the back works or a result is stalled,
// until its two-entry queue is full

module tagged_stack_alu #(
    parameter int DATA_WIDTH  = tsalu_pkg::DATA_WIDTH_DEF,
    parameter int STACK_DEPTH = tsalu_pkg::STACK_DEPTH_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // input words
    input  wire logic                                i_valid,
    output logic                                     o_stall,
    input  wire logic [1:0]                          i_operation,
    input  wire logic [3:0]                          i_opcode,
    input  wire logic [tsalu_pkg::PUSH_VALUE_W-1:0]  i_push_value,
    input  wire logic [1:0]                          i_push_type,
    // result words
    output logic                                     o_valid,
    input  wire logic                                i_stall,
    output logic [2:0]                               o_status,
    output logic [tsalu_pkg::PUSH_VALUE_W-1:0]       o_result_value,
    output logic [1:0]                               o_result_type,
    output logic [tsalu_pkg::DEPTH_OUT_W-1:0]        o_stack_depth
);

    // queue between front and back
    logic                  w_q_valid;
    tsalu_pkg::t_cmd       w_q_cmd;
    logic [DATA_WIDTH-1:0] w_q_value;
    logic                  w_q_pop;

    // front: takes words, tags each with its kind and whether its opcode is known
    tsalu_front #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_operation  (i_operation),
        .i_opcode     (i_opcode),
        .i_push_value (i_push_value),
        .i_push_type  (i_push_type),
        .o_q_valid    (w_q_valid),
        .o_q_cmd      (w_q_cmd),
        .o_q_value    (w_q_value),
        .i_q_pop      (w_q_pop)
    );

    // back: pops operands, checks tags, computes, pushes and registers the result
    tsalu_back #(
        .DATA_WIDTH  (DATA_WIDTH),
        .STACK_DEPTH (STACK_DEPTH)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_valid      (w_q_valid),
        .i_q_cmd        (w_q_cmd),
        .i_q_value      (w_q_value),
        .o_q_pop        (w_q_pop),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_status       (o_status),
        .o_result_value (o_result_value),
        .o_result_type  (o_result_type),
        .o_stack_depth  (o_stack_depth)
    );

endmodule

`default_nettype wire
